// ===== src/tpts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpts_pkg: shared types and constants for the traffic light sequencer
// Timing constants, lamp bit positions, register indexes and the result record.
// ----------------------------------------------------------------------------
package tpts_pkg;

  localparam int unsigned TICK_W = 5;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned LAMP_W = 6;

  localparam logic [TICK_W-1:0] TICKS_PER_SECOND = 5'd20;
  localparam logic [CNT_W-1:0]  YELLOW_SECONDS   = 8'd3;
  localparam logic [TICK_W-1:0] MID_TICK_P0      = 5'd5;
  localparam logic [TICK_W-1:0] MID_TICK_P1      = 5'd10;

  localparam logic [LAMP_W-1:0] L_NS_RED = 6'b000001;
  localparam logic [LAMP_W-1:0] L_NS_YEL = 6'b000010;
  localparam logic [LAMP_W-1:0] L_NS_GRN = 6'b000100;
  localparam logic [LAMP_W-1:0] L_EW_RED = 6'b001000;
  localparam logic [LAMP_W-1:0] L_EW_YEL = 6'b010000;
  localparam logic [LAMP_W-1:0] L_EW_GRN = 6'b100000;

  localparam logic [CNT_W-1:0] MAIN_A_RESET  = 8'd63;
  localparam logic [CNT_W-1:0] MAIN_B_RESET  = 8'd60;
  localparam logic [CNT_W-1:0] MINOR_A_RESET = 8'd33;
  localparam logic [CNT_W-1:0] MINOR_B_RESET = 8'd30;

  typedef enum logic [1:0] {
    REG_MAIN_A  = 2'd0,
    REG_MAIN_B  = 2'd1,
    REG_MINOR_A = 2'd2,
    REG_MINOR_B = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic             display_hold;
    logic [CNT_W-1:0] count_b;
    logic [CNT_W-1:0] count_a;
    logic [LAMP_W-1:0] lamps;
  } result_t;

endpackage
`default_nettype wire

// ===== src/two_phase_traffic_light_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_phase_traffic_light_sequencer_unit: two-phase junction light sequencer
// Send one request per 50 ms tick on s_* carrying the sampled switch level;
// each request yields one result on m_* with the six lamp bits, both
// countdown values and the hold display flag after that tick.
// Each accepted request's result is registered; one request is taken every
// cycle while s_tready is high, set by the single-pass next-state logic. An
// output register and a skid register part the two sides, so a new request is
// still taken while one finished result waits; s_tready drops only when
// both hold a result. Reset clears both valid flags, loads the timing
// registers with their defaults and puts the sequencer in phase zero with
// north-south green and east-west red. While m_tready is low results are
// held unchanged. Write cfg_data to register cfg_index with cfg_we while
// the block is idle.
// ----------------------------------------------------------------------------
module two_phase_traffic_light_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] switch_level, [7:1] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [0] ns_red, [1] ns_yellow, [2] ns_green,
                                      // [3] ew_red, [4] ew_yellow, [5] ew_green,
                                      // [13:6] count_a, [21:14] count_b,
                                      // [22] display_hold, [23] zero
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [tpts_pkg::CNT_W-1:0] main_a, main_b, minor_a, minor_b;

  logic [tpts_pkg::TICK_W-1:0] tick_count, tick_count_next;
  logic [tpts_pkg::CNT_W-1:0]  counter_a, counter_a_next;
  logic [tpts_pkg::CNT_W-1:0]  counter_b, counter_b_next;
  logic                        phase, phase_next;
  logic                        restart_pending, restart_pending_next;
  logic                        flash_direction, flash_direction_next;
  logic                        flash_enable, flash_enable_next;
  logic [tpts_pkg::LAMP_W-1:0] lamp_bits, lamp_bits_next;
  logic                        hold_display, hold_display_next;

  tpts_pkg::result_t result, out_data, skid_data;
  logic              out_valid, skid_valid;
  logic              push, pop;

  assign s_tready = !skid_valid;
  assign push     = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_a  <= tpts_pkg::MAIN_A_RESET;
      main_b  <= tpts_pkg::MAIN_B_RESET;
      minor_a <= tpts_pkg::MINOR_A_RESET;
      minor_b <= tpts_pkg::MINOR_B_RESET;
    end else if (cfg_we) begin
      case (tpts_pkg::reg_index_t'(cfg_index))
        tpts_pkg::REG_MAIN_A:  main_a  <= cfg_data;
        tpts_pkg::REG_MAIN_B:  main_b  <= cfg_data;
        tpts_pkg::REG_MINOR_A: minor_a <= cfg_data;
        tpts_pkg::REG_MINOR_B: minor_b <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                         fa, fb;
    logic [tpts_pkg::TICK_W-1:0]  mid_tick;
    tick_count_next      = tick_count + 1'b1;
    counter_a_next       = counter_a;
    counter_b_next       = counter_b;
    phase_next           = phase;
    restart_pending_next = restart_pending;
    flash_direction_next = flash_direction;
    flash_enable_next    = flash_enable;
    lamp_bits_next       = lamp_bits;
    hold_display_next    = hold_display;
    mid_tick             = phase ? tpts_pkg::MID_TICK_P1 : tpts_pkg::MID_TICK_P0;
    fa                   = 1'b0;
    fb                   = 1'b0;

    if (!s_tdata[0]) begin
      hold_display_next    = 1'b1;
      phase_next           = 1'b0;
      lamp_bits_next       = tpts_pkg::L_NS_RED | tpts_pkg::L_EW_RED;
      counter_a_next       = main_a;
      counter_b_next       = main_b;
      tick_count_next      = '0;
      restart_pending_next = 1'b1;
    end else begin
      hold_display_next = 1'b0;
      if (restart_pending) begin
        lamp_bits_next       = tpts_pkg::L_NS_GRN | tpts_pkg::L_EW_RED;
        restart_pending_next = 1'b0;
        tick_count_next      = '0;
      end

      // mid-second lamp change
      if (tick_count_next == mid_tick) begin
        fb = (counter_b <= tpts_pkg::YELLOW_SECONDS) && !flash_direction && flash_enable;
        fa = (counter_a <= tpts_pkg::YELLOW_SECONDS) && flash_direction && flash_enable;
        if (!phase) begin
          if (fb) lamp_bits_next = lamp_bits_next & ~(tpts_pkg::L_EW_GRN | tpts_pkg::L_EW_YEL);
          if (fa) lamp_bits_next = lamp_bits_next & ~(tpts_pkg::L_NS_GRN | tpts_pkg::L_NS_YEL);
        end else begin
          if (fb) lamp_bits_next = lamp_bits_next & ~(tpts_pkg::L_NS_GRN | tpts_pkg::L_NS_YEL);
          if (fa) lamp_bits_next = lamp_bits_next & ~(tpts_pkg::L_EW_GRN | tpts_pkg::L_EW_YEL);
        end
      end

      // second boundary
      if (tick_count_next == tpts_pkg::TICKS_PER_SECOND) begin
        tick_count_next = '0;
        counter_a_next  = counter_a - 1'b1;
        counter_b_next  = counter_b - 1'b1;
        fb = (counter_b_next <= tpts_pkg::YELLOW_SECONDS) && !flash_direction
             && flash_enable;
        fa = (counter_a_next <= tpts_pkg::YELLOW_SECONDS) && flash_direction
             && flash_enable;
        if (fb) lamp_bits_next = (lamp_bits_next & ~tpts_pkg::L_NS_GRN) | tpts_pkg::L_NS_YEL;
        if (fa) lamp_bits_next = (lamp_bits_next & ~tpts_pkg::L_EW_GRN) | tpts_pkg::L_EW_YEL;
        if (counter_a_next == '0 && counter_b_next == tpts_pkg::YELLOW_SECONDS) begin
          counter_a_next    = tpts_pkg::YELLOW_SECONDS;
          flash_enable_next = 1'b1;
        end
        if (counter_a_next == tpts_pkg::YELLOW_SECONDS && counter_b_next == '0) begin
          counter_b_next    = tpts_pkg::YELLOW_SECONDS;
          flash_enable_next = 1'b1;
        end
        if (counter_a_next == '0 && counter_b_next == '0) begin
          flash_direction_next = !flash_direction;
          flash_enable_next    = 1'b0;
          if (!phase) begin
            lamp_bits_next = tpts_pkg::L_NS_RED | tpts_pkg::L_EW_GRN;
            counter_a_next = minor_a;
            counter_b_next = minor_b;
            phase_next     = 1'b1;
          end else begin
            lamp_bits_next = tpts_pkg::L_NS_GRN | tpts_pkg::L_EW_RED;
            counter_a_next = main_a;
            counter_b_next = main_b;
            phase_next     = 1'b0;
          end
        end
      end
    end

    result.lamps        = lamp_bits_next;
    result.count_a      = counter_a_next;
    result.count_b      = counter_b_next;
    result.display_hold = hold_display_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      counter_a       <= tpts_pkg::MAIN_A_RESET;
      counter_b       <= tpts_pkg::MAIN_B_RESET;
      phase           <= 1'b0;
      restart_pending <= 1'b0;
      flash_direction <= 1'b0;
      flash_enable    <= 1'b0;
      lamp_bits       <= tpts_pkg::L_NS_GRN | tpts_pkg::L_EW_RED;
      hold_display    <= 1'b0;
    end else if (push) begin
      tick_count      <= tick_count_next;
      counter_a       <= counter_a_next;
      counter_b       <= counter_b_next;
      phase           <= phase_next;
      restart_pending <= restart_pending_next;
      flash_direction <= flash_direction_next;
      flash_enable    <= flash_enable_next;
      lamp_bits       <= lamp_bits_next;
      hold_display    <= hold_display_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) skid_data <= result;
      end else if (push) begin
        out_data <= result;
      end
    end else if (push) begin
      skid_data <= result;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for two_phase_traffic_light_sequencer_unit
// Streams switch ticks into the sequencer in bursts, with random gaps. An
// in-bench model of the junction tracks the lamps, the countdowns and the
// hold flag, and checks every result against it. The receiver stalls on its
// own pattern. Timing registers are rewritten between phases: the defaults,
// the extremes, the yellow reload cases and random times, mostly small.
// ----------------------------------------------------------------------------
module tb;

  localparam int TICK_TARGET = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 80;

  class junction_tracker;
    logic [tpts_pkg::CNT_W-1:0]  main_a, main_b, minor_a, minor_b;
    logic [tpts_pkg::TICK_W-1:0] ticks;
    logic [tpts_pkg::CNT_W-1:0]  cnt_a, cnt_b;
    logic                        phase_one, restart_due, flash_dir, flash_on, hold_shown;
    logic [tpts_pkg::LAMP_W-1:0] lamps;
    tpts_pkg::result_t           due[$];
    int                          errors;
    string lamp_name[tpts_pkg::LAMP_W] = '{"ns_red", "ns_yellow", "ns_green",
                                           "ew_red", "ew_yellow", "ew_green"};

    function new();
      main_a = tpts_pkg::MAIN_A_RESET;
      main_b = tpts_pkg::MAIN_B_RESET;
      minor_a = tpts_pkg::MINOR_A_RESET;
      minor_b = tpts_pkg::MINOR_B_RESET;
      ticks = '0;
      cnt_a = tpts_pkg::MAIN_A_RESET;
      cnt_b = tpts_pkg::MAIN_B_RESET;
      phase_one = 1'b0;
      restart_due = 1'b0;
      flash_dir = 1'b0;
      flash_on = 1'b0;
      hold_shown = 1'b0;
      lamps = tpts_pkg::L_NS_GRN | tpts_pkg::L_EW_RED;
      errors = 0;
    endfunction

    function void set_time(tpts_pkg::reg_index_t idx, logic [tpts_pkg::CNT_W-1:0] value);
      case (idx)
        tpts_pkg::REG_MAIN_A:  main_a = value;
        tpts_pkg::REG_MAIN_B:  main_b = value;
        tpts_pkg::REG_MINOR_A: minor_a = value;
        tpts_pkg::REG_MINOR_B: minor_b = value;
        default: ;
      endcase
    endfunction

    function bit b_flashing();
      return cnt_b <= tpts_pkg::YELLOW_SECONDS && !flash_dir && flash_on;
    endfunction

    function bit a_flashing();
      return cnt_a <= tpts_pkg::YELLOW_SECONDS && flash_dir && flash_on;
    endfunction

    // Count down one second; true when both countdowns ran out.
    function bit second_up();
      ticks = '0;
      cnt_a = cnt_a - 8'd1;
      cnt_b = cnt_b - 8'd1;
      if (b_flashing()) lamps = (lamps & ~tpts_pkg::L_NS_GRN) | tpts_pkg::L_NS_YEL;
      if (a_flashing()) lamps = (lamps & ~tpts_pkg::L_EW_GRN) | tpts_pkg::L_EW_YEL;
      if (cnt_a == 8'd0 && cnt_b == tpts_pkg::YELLOW_SECONDS) begin
        cnt_a = tpts_pkg::YELLOW_SECONDS;
        flash_on = 1'b1;
      end
      if (cnt_a == tpts_pkg::YELLOW_SECONDS && cnt_b == 8'd0) begin
        cnt_b = tpts_pkg::YELLOW_SECONDS;
        flash_on = 1'b1;
      end
      if (cnt_a == 8'd0 && cnt_b == 8'd0) begin
        flash_dir = !flash_dir;
        flash_on = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_tick(logic level);
      tpts_pkg::result_t r;
      ticks = ticks + 5'd1;
      if (!level) begin
        hold_shown = 1'b1;
        phase_one = 1'b0;
        lamps = tpts_pkg::L_NS_RED | tpts_pkg::L_EW_RED;
        cnt_a = main_a;
        cnt_b = main_b;
        ticks = '0;
        restart_due = 1'b1;
      end else begin
        hold_shown = 1'b0;
        if (restart_due) begin
          lamps = tpts_pkg::L_NS_GRN | tpts_pkg::L_EW_RED;
          restart_due = 1'b0;
          ticks = '0;
        end
        if (!phase_one) begin
          if (ticks == tpts_pkg::MID_TICK_P0) begin
            if (b_flashing()) lamps &= ~(tpts_pkg::L_EW_GRN | tpts_pkg::L_EW_YEL);
            if (a_flashing()) lamps &= ~(tpts_pkg::L_NS_GRN | tpts_pkg::L_NS_YEL);
          end
          if (ticks == tpts_pkg::TICKS_PER_SECOND) begin
            if (second_up()) begin
              lamps = tpts_pkg::L_NS_RED | tpts_pkg::L_EW_GRN;
              cnt_a = minor_a;
              cnt_b = minor_b;
              phase_one = 1'b1;
            end
          end
        end else begin
          if (ticks == tpts_pkg::MID_TICK_P1) begin
            if (b_flashing()) lamps &= ~(tpts_pkg::L_NS_GRN | tpts_pkg::L_NS_YEL);
            if (a_flashing()) lamps &= ~(tpts_pkg::L_EW_GRN | tpts_pkg::L_EW_YEL);
          end
          if (ticks == tpts_pkg::TICKS_PER_SECOND) begin
            if (second_up()) begin
              lamps = tpts_pkg::L_NS_GRN | tpts_pkg::L_EW_RED;
              cnt_a = main_a;
              cnt_b = main_b;
              phase_one = 1'b0;
            end
          end
        end
      end
      r.lamps = lamps;
      r.count_a = cnt_a;
      r.count_b = cnt_b;
      r.display_hold = hold_shown;
      due.push_back(r);
    endfunction

    function void flag(string field, int want, int got);
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    endfunction

    function void match_lamps(logic [23:0] word);
      tpts_pkg::result_t got, want;
      got = tpts_pkg::result_t'(word[22:0]);
      if (due.size() == 0) begin
        $error("result 0x%h with nothing pending", word);
        errors++;
        return;
      end
      want = due.pop_front();
      for (int i = 0; i < tpts_pkg::LAMP_W; i++)
        if (got.lamps[i] !== want.lamps[i]) flag(lamp_name[i], want.lamps[i], got.lamps[i]);
      if (got.count_a !== want.count_a) flag("count_a", want.count_a, got.count_a);
      if (got.count_b !== want.count_b) flag("count_b", want.count_b, got.count_b);
      if (got.display_hold !== want.display_hold)
        flag("display_hold", want.display_hold, got.display_hold);
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = tpts_pkg::REG_MAIN_A;
  logic [7:0]  cfg_data = 8'd0;

  junction_tracker book = new();
  int ticks_sent = 0;
  int burst_left = 0;
  int cycles = 0;
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int pattern_left = 0;
  int stall_pct = 0;

  two_phase_traffic_light_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver: check each result, stall on a changing pattern, hold off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) book.match_lamps(m_tdata);
      if (hold_off_req) begin
        hold_left = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(10, 120);
        case ($urandom_range(0, 3))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_tick(input logic level, input bit steady);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, level};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.take_tick(level);
    ticks_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic run_phase(input int count, input bit steady, input int hold_odds);
    for (int i = 0; i < count; i++)
      send_tick(($urandom_range(0, 999) < hold_odds) ? 1'b0 : 1'b1, steady);
  endtask

  // Drop valid and wait out every pending result plus the pipeline.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input tpts_pkg::reg_index_t idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    book.set_time(idx, value);
  endtask

  task automatic start_phase(input logic [7:0] ma, mb, na, nb);
    drain();
    put_reg(tpts_pkg::REG_MAIN_A, ma);
    put_reg(tpts_pkg::REG_MAIN_B, mb);
    put_reg(tpts_pkg::REG_MINOR_A, na);
    put_reg(tpts_pkg::REG_MINOR_B, nb);
    cfg_we <= 1'b0;
    send_tick(1'b0, 1'b1);
  endtask

  task automatic pick_pair(output logic [7:0] x, output logic [7:0] y);
    logic [7:0] t;
    case ($urandom_range(0, 4))
      0: begin
        x = 8'($urandom_range(0, 255));
        y = 8'($urandom_range(0, 255));
      end
      1, 2: begin
        x = 8'($urandom_range(0, 6));
        y = x;
      end
      default: begin
        x = 8'($urandom_range(0, 4));
        y = x + 8'd3;
        if ($urandom_range(0, 1) == 1) begin
          t = x;
          x = y;
          y = t;
        end
      end
    endcase
  endtask

  initial begin
    logic [7:0] ma, mb, na, nb;
    int phase_no;
    int count;
    bit steady;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_phase(25, 1'b0, 0);
    start_phase(8'd0, 8'd0, 8'd255, 8'd255);
    send_tick(1'b0, 1'b0);
    run_phase(30, 1'b0, 0);
    start_phase(8'd1, 8'd4, 8'd4, 8'd1);
    run_phase(190, 1'b0, 0);
    start_phase(8'd255, 8'd255, 8'd0, 8'd0);
    run_phase(25, 1'b0, 0);

    phase_no = 0;
    while (ticks_sent < TICK_TARGET) begin
      pick_pair(ma, mb);
      pick_pair(na, nb);
      start_phase(ma, mb, na, nb);
      steady = ($urandom_range(0, 3) == 0);
      if (phase_no == 1 || $urandom_range(0, 5) == 0) begin
        hold_off_req = 1'b1;
        steady = 1'b1;
      end
      count = $urandom_range(100, 300);
      if (count > TICK_TARGET - ticks_sent) count = TICK_TARGET - ticks_sent;
      run_phase(count, steady, 3);
      phase_no++;
    end

    drain();
    if (book.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
